@@ rtl/ukgt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the identifier-keyed geometry table.
// Used by the channel interfaces, the table engine, the top level and the checker.
package ukgt_pkg;

  // Request opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Width of the count shown on the result word
  localparam int unsigned COUNT_OUT_W = 7;

  // Result status codes
  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_CREATED  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_NULLKEY  = 3'd5
  } status_e;

  // One request word
  typedef struct packed {
    logic               opcode;
    logic [63:0]        key_high;
    logic [63:0]        key_low;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        win_width;
    logic [15:0]        win_height;
  } req_t;

  // One result word
  typedef struct packed {
    logic                   success;
    status_e                status;
    logic [COUNT_OUT_W-1:0] count_after;
  } rsp_t;

  // Pack geometry the way the store keeps it: x low, height high
  function automatic logic [63:0] pack_geometry(req_t r);
    pack_geometry = {r.win_height, r.win_width, r.pos_y, r.pos_x};
  endfunction

endpackage

@@ rtl/ukgt_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result words.
// Depends on ukgt_pkg for the status code type.
interface ukgt_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [63:0]        key_high;
  logic [63:0]        key_low;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        win_width;
  logic [15:0]        win_height;

  modport source (output valid, opcode, key_high, key_low, pos_x, pos_y,
                  win_width, win_height, input ready);
  modport sink   (input valid, opcode, key_high, key_low, pos_x, pos_y,
                  win_width, win_height, output ready);
endinterface

interface ukgt_rsp_if;
  logic              valid;
  logic              ready;
  logic              success;
  ukgt_pkg::status_e status;
  logic [6:0]        count_after;

  modport source (output valid, success, status, count_after, input ready);
  modport sink   (input valid, success, status, count_after, output ready);
endinterface

@@ rtl/uuid_keyed_geometry_table_core.sv @@
`timescale 1ns / 1ps
// Top level of the identifier-keyed window geometry table.
// Depends on ukgt_pkg, the channel interfaces in ukgt_if and ukgt_table.
//
// Usage:
//   req_i carries one request word: opcode (update/insert or delete), a
//   128-bit key as two 64-bit halves and the window geometry. rsp_o returns
//   exactly one result word per request: success, status and the occupied
//   count after the request. Both channels move a word when valid and ready
//   are high at a rising edge of clk_i.
//   Each request scans all ENTRIES stored keys through the key memory read
//   port, one key per cycle, then passes a drain state and commits; the
//   result is loaded into the output register at the commit. A request with
//   an all-zero key skips the scan and goes straight to the commit. A new
//   request is taken the cycle after the commit, not before; the single
//   memory read port sets the pace of the scan.
//   After rst_ni is released a clearing pass writes zero to every key and
//   geometry entry, with req_i.ready low.
//   The output register lets the next request scan while a result waits;
//   if the receiver still stalls at commit time, the commit waits for it.
module uuid_keyed_geometry_table_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ukgt_req_if.sink   req_i,
  ukgt_rsp_if.source rsp_o
);

  ukgt_pkg::req_t req;
  ukgt_pkg::rsp_t tbl_rsp;
  ukgt_pkg::rsp_t out_q;
  logic           out_vld_q;
  logic           out_free;
  logic           tbl_idle;
  logic           tbl_done;
  logic           start;

  // Gather the request word
  assign req.opcode     = req_i.opcode;
  assign req.key_high   = req_i.key_high;
  assign req.key_low    = req_i.key_low;
  assign req.pos_x      = req_i.pos_x;
  assign req.pos_y      = req_i.pos_y;
  assign req.win_width  = req_i.win_width;
  assign req.win_height = req_i.win_height;

  assign req_i.ready = tbl_idle;
  assign start       = req_i.valid && tbl_idle;
  assign out_free    = !out_vld_q || rsp_o.ready;

  ukgt_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .out_free_i (out_free),
    .idle_o     (tbl_idle),
    .done_o     (tbl_done),
    .rsp_o      (tbl_rsp)
  );

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (tbl_done) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_done) out_q <= tbl_rsp;
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.success     = out_q.success;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.count_after = out_q.count_after;

endmodule

@@ rtl/ukgt_table.sv @@
`timescale 1ns / 1ps
// Table engine: key and geometry memories, clearing pass, key scan and commit.
// Depends on ukgt_pkg for request/result words and status codes.
module ukgt_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ukgt_pkg::req_t req_i,
  input  logic           out_free_i,
  output logic           idle_o,
  output logic           done_o,
  output ukgt_pkg::rsp_t rsp_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned OUT_W = ukgt_pkg::COUNT_OUT_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             last_addr;
  logic             rd_en;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [127:0]     key_rd_q;
  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [CNT_W-1:0] count_q, count_d;
  ukgt_pkg::req_t   req_q;
  logic             null_q;

  logic             key_we, geo_we;
  logic [IDX_W-1:0] waddr;
  logic [127:0]     key_wdata;
  logic [63:0]      geo_wdata;
  logic             commit;
  logic             rd_match, rd_empty;
  logic [CNT_W+OUT_W-1:0] count_ext;

  logic [127:0] key_mem [ENTRIES];
  logic [63:0]  geo_mem [ENTRIES];

  assign last_addr = (addr_q == IDX_W'(ENTRIES - 1));
  assign rd_en     = (state_q == S_SCAN);
  assign commit    = (state_q == S_COMMIT) && out_free_i;
  assign idle_o    = (state_q == S_IDLE);
  assign done_o    = commit;

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[waddr] <= key_wdata;
    if (rd_en)  key_rd_q <= key_mem[addr_q];
  end

  // Geometry memory: written on create, update, delete and clear
  always_ff @(posedge clk_i) begin
    if (geo_we) geo_mem[waddr] <= geo_wdata;
  end

  // Sequence the clearing pass, the scan and the commit
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      S_CLEAR: begin
        addr_d = last_addr ? '0 : addr_q + 1'b1;
        if (last_addr) state_d = S_IDLE;
      end
      S_IDLE: begin
        addr_d = '0;
        if (start_i) begin
          state_d = (req_i.key_high == '0 && req_i.key_low == '0) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        addr_d = last_addr ? '0 : addr_q + 1'b1;
        if (last_addr) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_COMMIT;
      S_COMMIT: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Compare each key read against the request and against empty
  assign rd_match = (key_rd_q == {req_q.key_high, req_q.key_low});
  assign rd_empty = (key_rd_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      count_q    <= '0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      rd_vld_q <= rd_en;
      count_q  <= count_d;
      if (start_i && state_q == S_IDLE) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_vld_q) begin
        // keep the lowest-numbered match and the lowest-numbered empty slot
        if (rd_match && !hit_q)  hit_q  <= 1'b1;
        if (rd_empty && !free_q) free_q <= 1'b1;
      end
    end
  end

  // Hold request and found slot indexes
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (start_i && state_q == S_IDLE) begin
      req_q  <= req_i;
      null_q <= (req_i.key_high == '0 && req_i.key_low == '0);
    end
    if (rd_vld_q && rd_match && !hit_q)  hit_idx_q  <= rd_idx_q;
    if (rd_vld_q && rd_empty && !free_q) free_idx_q <= rd_idx_q;
  end

  // Decide the outcome, drive the write port and build the result word
  always_comb begin
    key_we       = 1'b0;
    geo_we       = 1'b0;
    waddr        = addr_q;
    key_wdata    = '0;
    geo_wdata    = '0;
    count_d      = count_q;
    rsp_o.success = 1'b0;
    rsp_o.status  = ukgt_pkg::ST_NULLKEY;
    if (state_q == S_CLEAR) begin
      key_we = 1'b1;
      geo_we = 1'b1;
    end else if (state_q == S_COMMIT) begin
      if (null_q) begin
        rsp_o.status = ukgt_pkg::ST_NULLKEY;
      end else if (req_q.opcode == ukgt_pkg::OP_UPDATE) begin
        if (hit_q) begin
          geo_we        = commit;
          waddr         = hit_idx_q;
          geo_wdata     = ukgt_pkg::pack_geometry(req_q);
          rsp_o.success = 1'b1;
          rsp_o.status  = ukgt_pkg::ST_UPDATED;
        end else if (free_q) begin
          key_we        = commit;
          geo_we        = commit;
          waddr         = free_idx_q;
          key_wdata     = {req_q.key_high, req_q.key_low};
          geo_wdata     = ukgt_pkg::pack_geometry(req_q);
          count_d       = commit ? count_q + 1'b1 : count_q;
          rsp_o.success = 1'b1;
          rsp_o.status  = ukgt_pkg::ST_CREATED;
        end else begin
          rsp_o.status = ukgt_pkg::ST_FULL;
        end
      end else begin
        if (hit_q) begin
          key_we        = commit;
          geo_we        = commit;
          waddr         = hit_idx_q;
          if (commit && count_q != '0) count_d = count_q - 1'b1;
          rsp_o.success = 1'b1;
          rsp_o.status  = ukgt_pkg::ST_DELETED;
        end else begin
          rsp_o.status = ukgt_pkg::ST_NOTFOUND;
        end
      end
    end
    // Show the low bits of the count after this request
    count_ext         = {{OUT_W{1'b0}}, count_d};
    rsp_o.count_after = count_ext[OUT_W-1:0];
  end

endmodule

@@ rtl/ukgt_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the geometry table, attached to the top level by bind.
// Depends on ukgt_pkg for status codes.
module ukgt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_success_i,
  input ukgt_pkg::status_e rsp_status_i,
  input logic [6:0]        rsp_count_i
);

  // Stalled result word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_success_i)
      && $stable(rsp_status_i) && $stable(rsp_count_i))
    else $error("result word changed while stalled");

  // Success matches the effective status codes
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_success_i == (rsp_status_i == ukgt_pkg::ST_UPDATED
      || rsp_status_i == ukgt_pkg::ST_CREATED || rsp_status_i == ukgt_pkg::ST_DELETED))
    else $error("success flag disagrees with status");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // Clearing pass blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request ready during clearing pass");

endmodule

bind uuid_keyed_geometry_table_core ukgt_checker u_ukgt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_success_i (rsp_o.success),
  .rsp_status_i  (rsp_o.status),
  .rsp_count_i   (rsp_o.count_after)
);
